>>> hdl/rsc_pkg.sv
// rsc_pkg: shared types and constants for the replay sequence cache
// holds the opcode, status and state encodings and the table entry layout
// no dependencies
`timescale 1ns / 1ps

package rsc_pkg;

  // default number of keys the table can hold
  localparam int unsigned MaxKeysDefault = 16;

  localparam int unsigned IdW   = 64;
  localparam int unsigned InstW = 8;
  localparam int unsigned SeqW  = 64;

  typedef enum logic {
    OP_ADMIT = 1'b0,
    OP_PEEK  = 1'b1
  } opcode_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_REPLAY = 2'd1,
    ST_FULL   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_e;

  // one table entry: key plus last accepted sequence number
  typedef struct packed {
    logic [IdW-1:0]   id_high;
    logic [IdW-1:0]   id_low;
    logic [InstW-1:0] instance_nr;
    logic [SeqW-1:0]  seq;
  } entry_t;

endpackage

>>> hdl/rsc_if.sv
// rsc_req_if and rsc_rsp_if: valid/ready channels of the replay sequence cache
// request carries opcode, key and sequence; response carries status and seen flag
// depends on rsc_pkg
`timescale 1ns / 1ps

interface rsc_req_if
  import rsc_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             opcode;
  logic [IdW-1:0]   key_id_high;
  logic [IdW-1:0]   key_id_low;
  logic [InstW-1:0] key_instance;
  logic [SeqW-1:0]  sequence_req;

  modport source (
    output valid, opcode, key_id_high, key_id_low, key_instance, sequence_req,
    input  ready
  );
  modport sink (
    input  valid, opcode, key_id_high, key_id_low, key_instance, sequence_req,
    output ready
  );
endinterface

interface rsc_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       already_seen;

  modport source (
    output valid, status, already_seen,
    input  ready
  );
  modport sink (
    input  valid, status, already_seen,
    output ready
  );
endinterface

>>> hdl/rsc_ram.sv
// rsc_ram: entry storage of the replay sequence cache
// one write port and one read port, read data registered
// depends on rsc_pkg
`timescale 1ns / 1ps

module rsc_ram
  import rsc_pkg::*;
#(
  parameter int unsigned Depth = MaxKeysDefault,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  entry_t           wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output entry_t           rd_data_o
);

  entry_t mem [Depth];
  entry_t rd_data_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

>>> hdl/replay_sequence_cache.sv
// replay_sequence_cache: anti-replay table of the last accepted sequence per key
// linear search over the filled entries of one registered-read memory
// depends on rsc_pkg, rsc_if (rsc_req_if, rsc_rsp_if) and rsc_ram
//
//   channel  dir  transfer contents
//   req_i    in   opcode, key_id_high, key_id_low, key_instance, sequence_req
//   rsp_o    out  status, already_seen
//
// a request compares the filled entries in order, one after another, stopping at the
// first match, then a finish step decides, writes back and loads the result; on an empty
// table the request goes straight to the finish step. a new request is taken only in the
// idle state, once the last one has loaded its result. reset clears the state, the
// fill count and the output valid; entries at or above the fill count are never matched.
// the result waits in an output register; the next request is taken meanwhile,
// and its finish step holds until that register is free.
`timescale 1ns / 1ps

module replay_sequence_cache
  import rsc_pkg::*;
#(
  parameter int unsigned MAX_KEYS = MaxKeysDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  rsc_req_if.sink       req_i,
  rsc_rsp_if.source     rsp_o
);

  localparam int unsigned IdxW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;
  localparam int unsigned CntW = $clog2(MAX_KEYS + 1);
  localparam logic [CntW-1:0] FullCount = CntW'(MAX_KEYS);

  state_e state_q, state_d;

  logic [CntW-1:0]  used_q, used_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             hit_q, hit_d;
  logic [SeqW-1:0]  stored_seq_q, stored_seq_d;

  // latched request
  logic             op_q;
  logic [IdW-1:0]   key_hi_q;
  logic [IdW-1:0]   key_lo_q;
  logic [InstW-1:0] key_inst_q;
  logic [SeqW-1:0]  seq_q;

  // output register
  logic             out_valid_q, out_valid_d;
  logic [1:0]       out_status_q, out_status_d;
  logic             out_seen_q, out_seen_d;

  // memory ports
  logic             rd_en;
  logic [IdxW-1:0]  rd_addr;
  entry_t           rd_data;
  logic             wr_en;
  logic [IdxW-1:0]  wr_addr;
  entry_t           wr_data;

  logic             req_xfer;
  logic             out_free;
  logic             key_match;
  logic             last_entry;
  logic             seq_not_greater;
  logic             table_full;

  assign req_i.ready = (state_q == S_IDLE);
  assign req_xfer    = req_i.valid && req_i.ready;
  assign out_free    = !out_valid_q || rsp_o.ready;

  assign key_match = (rd_data.id_high == key_hi_q) && (rd_data.id_low == key_lo_q) &&
                     (rd_data.instance_nr == key_inst_q);
  assign last_entry      = ((CntW'(idx_q) + CntW'(1)) == used_q);
  assign seq_not_greater = (seq_q <= stored_seq_q);
  assign table_full      = (used_q == FullCount);

  rsc_ram #(
    .Depth (MAX_KEYS),
    .AddrW (IdxW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (req_xfer) begin
          state_d = (used_q == '0) ? S_FINISH : S_SCAN;
        end
      end
      S_SCAN: begin
        if (key_match || last_entry) begin
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // datapath and outputs of the walk
  always_comb begin
    idx_d        = idx_q;
    hit_d        = hit_q;
    stored_seq_d = stored_seq_q;
    used_d       = used_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    wr_en        = 1'b0;
    wr_addr      = idx_q;
    wr_data      = '{id_high: key_hi_q, id_low: key_lo_q, instance_nr: key_inst_q,
                     seq: seq_q};
    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_seen_d   = out_seen_q;

    unique case (state_q)
      S_IDLE: begin
        // start the walk at entry zero
        if (req_xfer) begin
          idx_d   = '0;
          hit_d   = 1'b0;
          rd_en   = 1'b1;
          rd_addr = '0;
        end
      end
      S_SCAN: begin
        // compare the entry just read, fetch the next one on a mismatch unless it was the last
        if (key_match) begin
          hit_d        = 1'b1;
          stored_seq_d = rd_data.seq;
        end else if (!last_entry) begin
          idx_d   = idx_q + IdxW'(1);
          rd_en   = 1'b1;
          rd_addr = idx_q + IdxW'(1);
        end
      end
      S_FINISH: begin
        // decide, write back and load the result
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = ST_OK;
          out_seen_d   = 1'b0;
          if (op_q == OP_PEEK) begin
            out_seen_d = hit_q && seq_not_greater;
          end else if (hit_q) begin
            if (seq_not_greater) begin
              out_status_d = ST_REPLAY;
            end else begin
              wr_en   = 1'b1;
              wr_addr = idx_q;
            end
          end else if (table_full) begin
            out_status_d = ST_FULL;
          end else begin
            wr_en   = 1'b1;
            wr_addr = used_q[IdxW-1:0];
            used_d  = used_q + CntW'(1);
          end
        end
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      used_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      used_q      <= used_d;
      out_valid_q <= out_valid_d;
    end
  end

  // walk and result payload
  always_ff @(posedge clk_i) begin
    idx_q        <= idx_d;
    hit_q        <= hit_d;
    stored_seq_q <= stored_seq_d;
    out_status_q <= out_status_d;
    out_seen_q   <= out_seen_d;
  end

  // request capture on transfer
  always_ff @(posedge clk_i) begin
    if (req_xfer) begin
      op_q       <= req_i.opcode;
      key_hi_q   <= req_i.key_id_high;
      key_lo_q   <= req_i.key_id_low;
      key_inst_q <= req_i.key_instance;
      seq_q      <= req_i.sequence_req;
    end
  end

  assign rsp_o.valid        = out_valid_q;
  assign rsp_o.status       = out_status_q;
  assign rsp_o.already_seen = out_seen_q;

endmodule
